// ===== src/assert_macros.svh =====
// Assertion macros shared by the JSON unescaper modules.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Condition must never hold.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== src/jsu_pkg.sv =====
// Shared types, constants and helper functions for the JSON unescaper.
// No dependencies.
package jsu_pkg;

   localparam int MAX_OUT     = 3;                  // results per request, max
   localparam int BIDX_W      = $clog2(MAX_OUT);
   localparam int QUEUE_DEPTH = 4;                  // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [2:0] {
      ST_BYTE    = 3'd0,
      ST_DONE    = 3'd1,
      ST_BADESC  = 3'd2,
      ST_BADHEX  = 3'd3,
      ST_NOQUOTE = 3'd4,
      ST_EOF     = 3'd5
   } status_type;

   // Everything one request produces: 1..3 results.
   typedef struct packed {
      status_type                   status;
      logic [BIDX_W-1:0]            last_idx;
      logic [MAX_OUT-1:0][7:0]      data;
   } job_type;

   function automatic job_type single_result(status_type st, logic [7:0] b);
      job_type j;
      j          = '0;
      j.status   = st;
      j.last_idx = '0;
      j.data[0]  = b;
      return j;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nibble(logic [7:0] c);
      logic [3:0] v;
      if (c <= 8'h39) v = c[3:0];
      else            v = c[3:0] + 4'd9;   // 'a'/'A' low nibble is 1
      return v;
   endfunction

   // Code point to UTF-8, one to three bytes.
   function automatic job_type utf8_encode(logic [15:0] cp);
      job_type j;
      j        = '0;
      j.status = ST_BYTE;
      if (cp[15:7] == '0) begin
         j.last_idx = BIDX_W'(0);
         j.data[0]  = cp[7:0];
      end else if (cp[15:11] == '0) begin
         j.last_idx = BIDX_W'(1);
         j.data[0]  = 8'hC0 | {3'b000, cp[10:6]};
         j.data[1]  = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         j.last_idx = BIDX_W'(2);
         j.data[0]  = 8'hE0 | {4'h0, cp[15:12]};
         j.data[1]  = 8'h80 | {2'b00, cp[11:6]};
         j.data[2]  = 8'h80 | {2'b00, cp[5:0]};
      end
      return j;
   endfunction

endpackage

// ===== src/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   req     | req_valid/req_stall  | req_kind, req_data_byte
//   rsp     | rsp_valid/rsp_stall  | rsp_out_byte, rsp_status, rsp_last_of_run
//
// One request is taken per cycle while the job queue has room; the decoder
// state updates in the accepting cycle, so a request may follow every cycle.
// Results leave at one per cycle, while not stalled, from a registered output
// stage; a \u escape that encodes to three bytes holds the back end for all three.
// Reset is synchronous: decoder goes idle, queue and output stage empty.
// req_stall rises only when the four-entry job queue is full; rsp_stall
// freezes the output register while it holds a result and, once the queue fills, the front end.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_last_of_run
);

   logic             push;
   jsu_pkg::job_type push_job;
   logic             q_full;
   logic             pop;
   logic             head_valid;
   jsu_pkg::job_type head_job;

   // Front end stalls only on a full queue.
   assign req_stall = q_full;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_job      (push_job)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== src/jsu_front.sv =====
// Front end: accepts requests, runs the string/escape decoder, builds jobs.
// Depends on jsu_pkg.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             req_kind,
   input  logic [7:0]       req_data_byte,
   output logic             push,
   output jsu_pkg::job_type push_job
);

   typedef enum logic [6:0] {
      MODE_IDLE = 7'b0000001,
      MODE_STR  = 7'b0000010,
      MODE_ESC  = 7'b0000100,
      MODE_HEX1 = 7'b0001000,
      MODE_HEX2 = 7'b0010000,
      MODE_HEX3 = 7'b0100000,
      MODE_HEX4 = 7'b1000000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic        accept;
   logic        hex_ok;
   logic [3:0]  nib;

   assign accept = req_valid && !req_stall;
   assign hex_ok = jsu_pkg::is_hex(req_data_byte);
   assign nib    = jsu_pkg::hex_nibble(req_data_byte);

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      push     = 1'b0;
      push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h00);
      if (accept) begin
         if (mode_ff == MODE_IDLE) begin
            if (!req_kind) begin
               if (req_data_byte == jsu_pkg::CH_QUOTE) begin
                  mode_in = MODE_STR;
               end else begin
                  push     = 1'b1;
                  push_job = jsu_pkg::single_result(jsu_pkg::ST_NOQUOTE, 8'h00);
               end
            end
         end else if (req_kind) begin
            mode_in  = MODE_IDLE;
            push     = 1'b1;
            push_job = jsu_pkg::single_result(jsu_pkg::ST_EOF, 8'h00);
         end else begin
            unique case (mode_ff)
               MODE_STR: begin
                  if (req_data_byte == jsu_pkg::CH_QUOTE) begin
                     mode_in  = MODE_IDLE;
                     push     = 1'b1;
                     push_job = jsu_pkg::single_result(jsu_pkg::ST_DONE, 8'h00);
                  end else if (req_data_byte == jsu_pkg::CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     push     = 1'b1;
                     push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, req_data_byte);
                  end
               end
               MODE_ESC: begin
                  push    = 1'b1;
                  mode_in = MODE_STR;
                  unique case (req_data_byte)
                     8'h22: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h22);
                     8'h5C: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h5C);
                     8'h2F: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h2F);
                     8'h62: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h08);
                     8'h66: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h0C);
                     8'h6E: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h0A);
                     8'h72: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h0D);
                     8'h74: push_job = jsu_pkg::single_result(jsu_pkg::ST_BYTE, 8'h09);
                     jsu_pkg::CH_U: begin
                        push    = 1'b0;
                        acc_in  = '0;
                        mode_in = MODE_HEX1;
                     end
                     default: begin
                        mode_in  = MODE_IDLE;
                        push_job = jsu_pkg::single_result(jsu_pkg::ST_BADESC, 8'h00);
                     end
                  endcase
               end
               MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                  if (!hex_ok) begin
                     mode_in  = MODE_IDLE;
                     push     = 1'b1;
                     push_job = jsu_pkg::single_result(jsu_pkg::ST_BADHEX, 8'h00);
                  end else begin
                     acc_in  = {acc_ff[7:0], nib};
                     mode_in = (mode_ff == MODE_HEX1) ? MODE_HEX2 :
                               (mode_ff == MODE_HEX2) ? MODE_HEX3 : MODE_HEX4;
                  end
               end
               MODE_HEX4: begin
                  push = 1'b1;
                  if (!hex_ok) begin
                     mode_in  = MODE_IDLE;
                     push_job = jsu_pkg::single_result(jsu_pkg::ST_BADHEX, 8'h00);
                  end else begin
                     mode_in  = MODE_STR;
                     acc_in   = '0;
                     push_job = jsu_pkg::utf8_encode({acc_ff, nib});
                  end
               end
               default: mode_in = MODE_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

// ===== src/jsu_queue.sv =====
// Small job queue between decoder front end and result back end.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::job_type head_job
);

   jsu_pkg::job_type             q_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QPTR_W:0]     count_ff, count_in;

   assign full       = count_ff == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = q_ff[rd_ptr_ff];

   // Pointers wrap naturally since depth is a power of two.
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + {{jsu_pkg::QPTR_W{1'b0}}, push}
                               - {{jsu_pkg::QPTR_W{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_NEVER(a_q_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_q_underflow, clock, reset, pop && !head_valid)
   `ASSERT_NEXT(a_q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== src/jsu_back.sv =====
// Back end: walks job bytes into the output register, one per unstalled cycle.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_status,
   output logic             rsp_last_of_run
);

   logic [jsu_pkg::BIDX_W-1:0] idx_ff, idx_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff;
   jsu_pkg::status_type        status_ff;
   logic                       last_ff;
   logic                       load;
   logic                       is_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign is_last = idx_ff == head_job.last_idx;
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head_job.data[idx_ff];
         status_ff <= head_job.status;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;

   `ASSERT_IMPLIES(a_bk_status_last, clock, reset, valid_ff && status_ff != jsu_pkg::ST_BYTE, last_ff)
   `ASSERT_IMPLIES(a_bk_idx_has_job, clock, reset, idx_ff != '0, head_valid)
   `ASSERT_IMPLIES(a_bk_idx_range, clock, reset, head_valid, idx_ff <= head_job.last_idx)

endmodule

// ===== tb/tb_top.sv =====
// Testbench for json_string_unescape_utf8: a directed table, then random JSON literals.
// Scoreboard is a cycle-free decoder model. Needs jsu_pkg and the RTL in src/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAND_ITEMS     = 190;   // random requests to feed
   localparam int IDLE_PCT       = 34;    // per-cycle idle/stall odds, percent
   localparam int HOLD_CYCLES    = 80;    // long output hold-off
   localparam int BURST_ITEMS    = 30;    // gapless requests during the hold-off
   localparam int DRAIN_CYCLES   = 10;    // settle time once nothing is pending
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

   // ASCII bytes used by the stimulus, beyond the package's quote, backslash, 'u'
   localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
   localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
   localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
   localparam logic [7:0] CH_LN    = 8'h6E;  // 'n'
   localparam logic [7:0] CH_LR    = 8'h72;  // 'r'
   localparam logic [7:0] CH_LT    = 8'h74;  // 't'
   localparam logic [7:0] CH_LQ    = 8'h71;  // 'q', not an escape
   localparam logic [7:0] CH_0     = 8'h30;  // '0'
   localparam logic [7:0] CH_7     = 8'h37;  // '7'
   localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
   localparam logic [7:0] CH_UG    = 8'h47;  // 'G', not hex

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Decoder position inside a literal
   typedef enum logic [6:0] {
      LM_IDLE = 7'b0000001,
      LM_STR  = 7'b0000010,
      LM_ESC  = 7'b0000100,
      LM_HEX1 = 7'b0001000,
      LM_HEX2 = 7'b0010000,
      LM_HEX3 = 7'b0100000,
      LM_HEX4 = 7'b1000000
   } lit_mode_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      jsu_pkg::status_type status;
      logic                last;
   } decoded_type;

   // One directed request; known=1 means the expected outcome is typed in
   // here (has=0: no result, has=1: exactly one result st/ob).
   typedef struct packed {
      logic                kind;
      logic [7:0]          data;
      logic                known;
      logic                has;
      jsu_pkg::status_type st;
      logic [7:0]          ob;
   } stim_row_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_kind      = KIND_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_status;
   logic       rsp_last_of_run;

   // Scoreboard state: model of the decoder plus results still owed
   lit_mode_type lit_mode  = LM_IDLE;
   logic [11:0]  cp_digits = '0;
   decoded_type  decoded_q [$];
   int           errors    = 0;

   // Traffic shaping shared by the sender and the receiver
   stim_row_type cur_row    = '0;
   bit           calm       = 1'b0;   // no idling on either side
   bit           hold_off   = 1'b0;   // asks the receiver for a long stall
   int           burst_left = 0;      // gapless requests still to send
   int           fed_items  = 0;

   logic [7:0] esc_letters [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, CH_SLASH, CH_LB,
                                   CH_LF, CH_LN, CH_LR, CH_LT};
   logic [15:0] cp_bounds [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                  16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

   // Directed table: reset behavior, byte extremes, escapes, UTF-8 widths and
   // every error path. Rows left to the model are the decoded escapes.
   stim_row_type directed_rows [29] = '{
      '{KIND_END,  8'h00,              1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // end, idle
      '{KIND_BYTE, 8'h00,              1'b1, 1'b1, jsu_pkg::ST_NOQUOTE, 8'h00}, // junk, idle
      '{KIND_BYTE, jsu_pkg::CH_QUOTE,  1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // open
      '{KIND_BYTE, 8'hFF,              1'b1, 1'b1, jsu_pkg::ST_BYTE,    8'hFF}, // raw byte
      '{KIND_BYTE, 8'h00,              1'b1, 1'b1, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // \n
      '{KIND_BYTE, CH_LN,              1'b0, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // \u07Ff
      '{KIND_BYTE, jsu_pkg::CH_U,      1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_0,               1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_7,               1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_UF,              1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_LF,              1'b0, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // \uFfFF
      '{KIND_BYTE, jsu_pkg::CH_U,      1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_UF,              1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_LF,              1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_UF,              1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_UF,              1'b0, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::ST_DONE,    8'h00}, // close
      '{KIND_BYTE, jsu_pkg::CH_QUOTE,  1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // bad escape
      '{KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_LQ,              1'b1, 1'b1, jsu_pkg::ST_BADESC,  8'h00},
      '{KIND_BYTE, jsu_pkg::CH_QUOTE,  1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // non-hex
      '{KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, jsu_pkg::CH_U,      1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00},
      '{KIND_BYTE, CH_UG,              1'b1, 1'b1, jsu_pkg::ST_BADHEX,  8'h00},
      '{KIND_BYTE, jsu_pkg::CH_QUOTE,  1'b1, 1'b0, jsu_pkg::ST_BYTE,    8'h00}, // end inside
      '{KIND_END,  8'h5A,              1'b1, 1'b1, jsu_pkg::ST_EOF,     8'h00}
   };

   json_string_unescape_utf8 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // -1 for anything that is not a hex digit
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   // Single-byte escapes; returns 0 for any other letter (\u included)
   function automatic bit short_escape(input logic [7:0] c, output logic [7:0] b);
      b = 8'h00;
      unique case (c)
         jsu_pkg::CH_QUOTE:  b = 8'h22;
         jsu_pkg::CH_BSLASH: b = 8'h5C;
         CH_SLASH:           b = 8'h2F;
         CH_LB:              b = 8'h08;
         CH_LF:              b = 8'h0C;
         CH_LN:              b = 8'h0A;
         CH_LR:              b = 8'h0D;
         CH_LT:              b = 8'h09;
         default:            return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return CH_0 + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // Advances the decoder model by one request; returns the number of
   // results it owes (0..3), the last one flagged.
   function automatic int decode_step(input logic kind, input logic [7:0] c,
                                      output decoded_type r [3]);
      int          n;
      int          d;
      logic [7:0]  b;
      logic [15:0] cp;
      n = 0;
      for (int i = 0; i < 3; i++) r[i] = '{8'h00, jsu_pkg::ST_BYTE, 1'b0};
      if (lit_mode == LM_IDLE) begin
         if (!kind) begin
            if (c == jsu_pkg::CH_QUOTE) begin
               lit_mode = LM_STR;
            end else begin
               r[0].status = jsu_pkg::ST_NOQUOTE;
               n = 1;
            end
         end
      end else if (kind) begin
         // end of input anywhere inside a literal
         lit_mode    = LM_IDLE;
         r[0].status = jsu_pkg::ST_EOF;
         n = 1;
      end else if (lit_mode == LM_STR) begin
         if (c == jsu_pkg::CH_QUOTE) begin
            lit_mode    = LM_IDLE;
            r[0].status = jsu_pkg::ST_DONE;
            n = 1;
         end else if (c == jsu_pkg::CH_BSLASH) begin
            lit_mode = LM_ESC;
         end else begin
            r[0].out_byte = c;
            n = 1;
         end
      end else if (lit_mode == LM_ESC) begin
         if (c == jsu_pkg::CH_U) begin
            cp_digits = '0;
            lit_mode  = LM_HEX1;
         end else if (short_escape(c, b)) begin
            lit_mode      = LM_STR;
            r[0].out_byte = b;
            n = 1;
         end else begin
            lit_mode    = LM_IDLE;
            r[0].status = jsu_pkg::ST_BADESC;
            n = 1;
         end
      end else begin
         d = hex_digit(c);
         if (d < 0) begin
            lit_mode    = LM_IDLE;
            r[0].status = jsu_pkg::ST_BADHEX;
            n = 1;
         end else if (lit_mode == LM_HEX4) begin
            cp        = {cp_digits, 4'(d)};
            lit_mode  = LM_STR;
            cp_digits = '0;
            // surrogate halves get no special treatment
            if (cp < 16'h0080) begin
               r[0].out_byte = cp[7:0];
               n = 1;
            end else if (cp < 16'h0800) begin
               r[0].out_byte = 8'hC0 | {3'b000, cp[10:6]};
               r[1].out_byte = 8'h80 | {2'b00, cp[5:0]};
               n = 2;
            end else begin
               r[0].out_byte = 8'hE0 | {4'h0, cp[15:12]};
               r[1].out_byte = 8'h80 | {2'b00, cp[11:6]};
               r[2].out_byte = 8'h80 | {2'b00, cp[5:0]};
               n = 3;
            end
         end else begin
            cp_digits = {cp_digits[7:0], 4'(d)};
            lit_mode  = (lit_mode == LM_HEX1) ? LM_HEX2 :
                        (lit_mode == LM_HEX2) ? LM_HEX3 : LM_HEX4;
         end
      end
      if (n > 0) r[n-1].last = 1'b1;
      return n;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("@%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // Offers one request at the falling edge and holds it until accepted.
   // Returns at the falling edge after the accepting rising edge, valid still
   // high, so the caller either drives the next request or lowers valid.
   task automatic send_item(input logic kind, input logic [7:0] data, input bit counts);
      if (!calm && burst_left == 0 && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counts) fed_items++;
      if (burst_left > 0) burst_left--;
      @(negedge clock);
   endtask

   // Scoreboard: model advances on every accepted request; each accepted
   // result is matched against the oldest owed one.
   always @(posedge clock) begin : scoreboard
      int          n;
      decoded_type step_res [3];
      decoded_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n = decode_step(req_kind, req_data_byte, step_res);
            if (cur_row.known) begin
               // model state still advances; the typed-in outcome is used
               if (cur_row.has)
                  decoded_q.insert(decoded_q.size(),
                                   decoded_type'{cur_row.ob, cur_row.st, 1'b1});
            end else begin
               for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("result with none pending, status", rsp_status, 0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_out_byte != want.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_last_of_run != want.last)
                  report_mismatch("last_of_run", rsp_last_of_run, want.last);
            end
         end
      end
   end

   // Receiver: random stalls, none while calm, and one long hold-off on request
   initial begin : rsp_side
      int hold_cnt;
      hold_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            rsp_stall <= 1'b1;
            hold_cnt--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: any handshake on either channel, or reset, restarts the count
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Sender: reset, directed table, then random literals
   initial begin : req_side
      int          n_el;
      int          sel;
      logic [7:0]  c;
      logic [7:0]  b;
      logic [15:0] cp;
      bit          held;
      bit          paused;
      held   = 1'b0;
      paused = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         cur_row = directed_rows[i];
         send_item(cur_row.kind, cur_row.data, 1'b1);
      end
      cur_row   = '0;
      fed_items = 0;

      while (fed_items < RAND_ITEMS) begin
         calm = (fed_items >= 40 && fed_items < 90);
         // fill the block: long output hold-off with a gapless burst behind it
         if (!held && fed_items >= 110) begin
            held       = 1'b1;
            hold_off   = 1'b1;
            burst_left = BURST_ITEMS;
         end
         // sender pause until every owed result is out
         if (!paused && fed_items >= 160) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (decoded_q.size() != 0) @(negedge clock);
         end

         // noise between literals: stray byte, or end marker while idle
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            do c = 8'($urandom); while (c == jsu_pkg::CH_QUOTE);
            send_item(KIND_BYTE, c, 1'b1);
         end else if (sel == 1) begin
            send_item(KIND_END, 8'($urandom), 1'b0);
         end

         // literal body: raw bytes, short escapes and \u code points
         send_item(KIND_BYTE, jsu_pkg::CH_QUOTE, 1'b1);
         n_el = $urandom_range(0, 6);
         for (int i = 0; i < n_el; i++) begin
            sel = $urandom_range(0, 19);
            if (sel < 8) begin
               do c = 8'($urandom);
               while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
               send_item(KIND_BYTE, c, 1'b1);
            end else if (sel < 13) begin
               send_item(KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1);
               send_item(KIND_BYTE, esc_letters[$urandom_range(0, 7)], 1'b1);
            end else begin
               sel = $urandom_range(0, 9);
               if (sel == 0)     cp = cp_bounds[$urandom_range(0, 7)];
               else if (sel < 4) cp = 16'($urandom_range(0, 16'h007F));
               else if (sel < 7) cp = 16'($urandom_range(16'h0080, 16'h07FF));
               else              cp = 16'($urandom_range(16'h0800, 16'hFFFF));
               send_item(KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1);
               send_item(KIND_BYTE, jsu_pkg::CH_U, 1'b1);
               for (int k = 3; k >= 0; k--)
                  send_item(KIND_BYTE, hex_char(cp[k*4 +: 4], 1'($urandom)), 1'b1);
            end
         end

         // ending: mostly a clean close, otherwise one of the error paths
         sel = $urandom_range(0, 19);
         if (sel < 15) begin
            send_item(KIND_BYTE, jsu_pkg::CH_QUOTE, 1'b1);
         end else if (sel == 15) begin
            do c = 8'($urandom); while (c == jsu_pkg::CH_U || short_escape(c, b));
            send_item(KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1);
            send_item(KIND_BYTE, c, 1'b1);
         end else if (sel == 16) begin
            send_item(KIND_END, 8'($urandom), 1'b1);
         end else if (sel == 17) begin
            send_item(KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1);
            send_item(KIND_END, 8'($urandom), 1'b1);
         end else begin
            // \u cut short after 0..3 digits by a non-hex byte or end marker
            send_item(KIND_BYTE, jsu_pkg::CH_BSLASH, 1'b1);
            send_item(KIND_BYTE, jsu_pkg::CH_U, 1'b1);
            n_el = $urandom_range(0, 3);
            for (int k = 0; k < n_el; k++)
               send_item(KIND_BYTE, hex_char(4'($urandom), 1'($urandom)), 1'b1);
            if (sel == 18) begin
               do c = 8'($urandom); while (hex_digit(c) >= 0);
               send_item(KIND_BYTE, c, 1'b1);
            end else begin
               send_item(KIND_END, 8'($urandom), 1'b1);
            end
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain; the watchdog catches results that never come
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
